// File: rtl/vcfc_pkg.sv
// Shared types and constants for the four-lane causal FIR filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package vcfc_pkg;

  // Sample format: signed Q8.8.
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * SAMPLE_W;

  // Lanes per vector and filter length.
  localparam int LANES    = 4;
  localparam int TAPS_DEF = 4;
  localparam int TAP_REGS = 4;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TAP_0 = 3'd0;
  localparam cfg_idx_t CFG_TAP_1 = 3'd1;
  localparam cfg_idx_t CFG_TAP_2 = 3'd2;
  localparam cfg_idx_t CFG_TAP_3 = 3'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Handshake status of the window stage.
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_stat_t;

endpackage

`default_nettype wire

// File: rtl/vcfc_window.sv
// Input stage: keeps the sample history and registers the filter window.
// Depends on vcfc_pkg.
`default_nettype none

module vcfc_window #(
  parameter int TAPS = vcfc_pkg::TAPS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  vcfc_pkg::sample_t    lanes_i [vcfc_pkg::LANES],
  input  wire                  start_i,
  input  wire                  advance_i,
  output vcfc_pkg::stage_stat_t stat_o,
  output vcfc_pkg::sample_t    win_o [vcfc_pkg::LANES + TAPS - 1]
);

  import vcfc_pkg::*;

  localparam int WinLen    = LANES + TAPS - 1;
  localparam int HistDepth = (TAPS > 1) ? TAPS - 1 : 1;

  logic    valid_q, valid_d;
  logic    accept;
  sample_t win_q [WinLen];
  sample_t hist_q [HistDepth];

  // A request is taken when the stage is empty or drains this cycle.
  assign stat_o.valid = valid_q;
  assign stat_o.stall = valid_q && !advance_i;
  assign accept       = in_valid_i && !stat_o.stall;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // New lanes open the window; the history forms its tail, and a start flag
  // replaces that tail by zeros.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < LANES; i++) begin
        win_q[i] <= lanes_i[i];
      end
      for (int i = 0; i < TAPS - 1; i++) begin
        win_q[LANES + i] <= start_i ? '0 : hist_q[i];
      end
    end
  end

  // The history then takes the leading lanes of the new vector.
  if (TAPS > 1) begin : g_hist
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < HistDepth; i++) begin
          hist_q[i] <= '0;
        end
      end else if (accept) begin
        for (int i = 0; i < HistDepth; i++) begin
          hist_q[i] <= lanes_i[i];
        end
      end
    end

    // The newest kept sample is lane 0 of the last accepted request.
    a_hist_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept |=> (hist_q[0] == $past(lanes_i[0])))
      else $error("history not updated from accepted lanes");
  end else begin : g_no_hist
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hist_q[0] <= '0;
      end else begin
        hist_q[0] <= hist_q[0];
      end
    end
  end

  assign win_o = win_q;

  // The stage only empties when the result register takes it.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !advance_i) |=> valid_q)
    else $error("window stage lost an item");

endmodule

`default_nettype wire

// File: rtl/vcfc_lane_mac.sv
// One output lane: tap products truncated to Q8.8 and summed with wrap.
// Depends on vcfc_pkg.
`default_nettype none

module vcfc_lane_mac #(
  parameter int TAPS = vcfc_pkg::TAPS_DEF
) (
  input  vcfc_pkg::sample_t taps_i [TAPS],
  input  vcfc_pkg::sample_t win_i  [TAPS],
  output vcfc_pkg::sample_t sum_o
);

  import vcfc_pkg::*;

  // Taking the bits above the fraction is a floor of the product; the
  // accumulator drops carries, which gives the wrapped sum.
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    sample_t                  acc;
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      prod = taps_i[k] * win_i[k];
      acc  = acc + sample_t'(prod[FRAC_BITS +: SAMPLE_W]);
    end
    sum_o = acc;
  end

endmodule

`default_nettype wire

// File: rtl/vector_causal_fir_conv.sv
// Top level of the four-lane causal FIR filter: tap registers, window
// stage, lane multiply-accumulate and result register.
// Depends on vcfc_pkg, vcfc_window and vcfc_lane_mac.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o   | sample_lane0..3_i, sequence_start_i
//   output   | out_valid_o / out_stall_i | result_lane0..3_o
//   config   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One request per cycle is taken while in_stall_o is low; its result passes
// the window register and then the result register before it can leave.
// The history is updated as a request is accepted, so consecutive requests
// need no gap. Reset clears the taps, the history and both valid flags.
// A stalled output holds the result; one more request waits in the window
// stage before in_stall_o rises.
`default_nettype none

module vector_causal_fir_conv #(
  parameter int TAPS = vcfc_pkg::TAPS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Configuration writes
  input  wire                 cfg_we_i,
  input  vcfc_pkg::cfg_idx_t  cfg_index_i,
  input  vcfc_pkg::sample_t   cfg_data_i,
  // Input requests
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  vcfc_pkg::sample_t   sample_lane0_i,
  input  vcfc_pkg::sample_t   sample_lane1_i,
  input  vcfc_pkg::sample_t   sample_lane2_i,
  input  vcfc_pkg::sample_t   sample_lane3_i,
  input  wire                 sequence_start_i,
  // Result requests
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output vcfc_pkg::sample_t   result_lane0_o,
  output vcfc_pkg::sample_t   result_lane1_o,
  output vcfc_pkg::sample_t   result_lane2_o,
  output vcfc_pkg::sample_t   result_lane3_o
);

  import vcfc_pkg::*;

  localparam int WinLen = LANES + TAPS - 1;

  sample_t     tap_q [TAP_REGS];
  sample_t     lanes [LANES];
  sample_t     win [WinLen];
  sample_t     sum [LANES];
  sample_t     result_q [LANES];
  logic        out_valid_q;
  logic        advance;
  stage_stat_t win_stat;

  // Tap registers; indexes beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_REGS; i++) begin
        tap_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TAP_0: tap_q[0] <= cfg_data_i;
        CFG_TAP_1: tap_q[1] <= cfg_data_i;
        CFG_TAP_2: tap_q[2] <= cfg_data_i;
        CFG_TAP_3: tap_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lanes[0] = sample_lane0_i;
  assign lanes[1] = sample_lane1_i;
  assign lanes[2] = sample_lane2_i;
  assign lanes[3] = sample_lane3_i;

  // The result register takes the window when it is empty or being drained.
  assign advance    = win_stat.valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = win_stat.stall;

  vcfc_window #(
    .TAPS (TAPS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .lanes_i   (lanes),
    .start_i   (sequence_start_i),
    .advance_i (advance),
    .stat_o    (win_stat),
    .win_o     (win)
  );

  // One multiply-accumulate per lane over its slice of the window.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    sample_t lane_taps [TAPS];
    sample_t lane_win  [TAPS];
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      assign lane_taps[k] = tap_q[k];
      assign lane_win[k]  = win[j + k];
    end
    vcfc_lane_mac #(
      .TAPS (TAPS)
    ) u_mac (
      .taps_i(lane_taps),
      .win_i (lane_win),
      .sum_o (sum[j])
    );
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= sum;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_lane0_o = result_q[0];
  assign result_lane1_o = result_q[1];
  assign result_lane2_o = result_q[2];
  assign result_lane3_o = result_q[3];

  // An accepted request always reaches the window stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> win_stat.valid)
    else $error("accepted request did not reach the window stage");

  // With a full window and a held result, no request may be taken.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_stat.valid && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("request taken while both stages are full");

  // A window that moves forward produces a result in the next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("window advanced without a result");

endmodule

`default_nettype wire
